@@ rtl/s2c_pkg.sv @@
package s2c_pkg;

  localparam int VEC_W = 44;
  localparam int ANG_W = 35;
  localparam int POS_W = 33;
  localparam int QUAT_W = 32;
  localparam int IN_ANG_W = 31;
  localparam int DIST_W = 32;
  localparam int GAIN_W = 30;

  localparam logic [GAIN_W-1:0] GAIN_K = 30'd652032874;
  localparam logic signed [ANG_W-1:0] ANG_PI = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd1686629713;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] val;
    case (idx)
      0: val = 32'h3243F6A8;
      1: val = 32'h1DAC6705;
      2: val = 32'h0FADBAFC;
      3: val = 32'h07F56EA6;
      4: val = 32'h03FEAB76;
      5: val = 32'h01FFD55B;
      6: val = 32'h00FFFAAA;
      7: val = 32'h007FFF55;
      8: val = 32'h003FFFEA;
      9: val = 32'h001FFFFD;
      10: val = 32'h000FFFFF;
      11: val = 32'h0007FFFF;
      12: val = 32'h0003FFFF;
      13: val = 32'h0001FFFF;
      14: val = 32'h0000FFFF;
      15: val = 32'h00007FFF;
      16: val = 32'h00003FFF;
      17: val = 32'h00001FFF;
      18: val = 32'h00000FFF;
      19: val = 32'h000007FF;
      20: val = 32'h000003FF;
      21: val = 32'h000001FF;
      22: val = 32'h000000FF;
      23: val = 32'h0000007F;
      24: val = 32'h0000003F;
      25: val = 32'h0000001F;
      26: val = 32'h0000000F;
      27: val = 32'h00000008;
      28: val = 32'h00000004;
      29: val = 32'h00000002;
      30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/s2c_gain.sv @@
module s2c_gain #(
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [s2c_pkg::VEC_W-1:0]   a,
  input  logic [SIDE_W-1:0]                  side_in,
  output logic                               out_valid,
  output logic signed [s2c_pkg::VEC_W-1:0]   result,
  output logic [SIDE_W-1:0]                  side_out
);

  localparam int VW = s2c_pkg::VEC_W;
  localparam int KW = s2c_pkg::GAIN_W;
  localparam int HW = VW - 16;
  localparam int HIP_W = HW + KW;
  localparam int LOP_W = 16 + KW;

  logic [1:0] vld;
  logic [VW-1:0] mag;
  logic [HIP_W-1:0] hi_prod;
  logic [LOP_W-1:0] lo_prod;
  logic neg;
  logic [SIDE_W-1:0] side1;
  logic [HIP_W:0] sum;
  logic [VW-1:0] scaled;

  assign mag = a[VW-1] ? VW'(-a) : VW'(a);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  // split magnitude times gain into two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hi_prod <= HIP_W'(mag[VW-1:16]) * HIP_W'(s2c_pkg::GAIN_K);
      lo_prod <= LOP_W'(mag[15:0]) * LOP_W'(s2c_pkg::GAIN_K);
      neg <= a[VW-1];
      side1 <= side_in;
    end
  end

  assign sum = (HIP_W+1)'(hi_prod) + (HIP_W+1)'(lo_prod[LOP_W-1:16]);
  assign scaled = sum[VW+13:14];

  always_ff @(posedge clk) begin
    if (en) begin
      result <= neg ? -$signed(scaled) : $signed(scaled);
      side_out <= side1;
    end
  end

  assign out_valid = vld[1];

  a_gain_sign: assert property (@(posedge clk) disable iff (rst)
    en && vld[0] && !neg |=> !result[VW-1])
    else $error("gain result negative for positive input");

endmodule

@@ rtl/s2c_cordic.sv @@
module s2c_cordic #(
  parameter int STAGES = 24,
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [s2c_pkg::VEC_W-1:0]   x0,
  input  logic signed [s2c_pkg::ANG_W-1:0]   angle,
  input  logic [SIDE_W-1:0]                  side_in,
  output logic                               out_valid,
  output logic signed [s2c_pkg::VEC_W-1:0]   cos_out,
  output logic signed [s2c_pkg::VEC_W-1:0]   sin_out,
  output logic [SIDE_W-1:0]                  side_out
);

  localparam int VW = s2c_pkg::VEC_W;
  localparam int AW = s2c_pkg::ANG_W;

  logic [STAGES:0] vld;
  logic signed [VW-1:0] xs [0:STAGES];
  logic signed [VW-1:0] ys [0:STAGES];
  logic signed [AW-1:0] zs [0:STAGES];
  logic [SIDE_W-1:0] sd [0:STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-1:0], in_valid};
    end
  end

  // fold angles beyond a quarter turn
  always_ff @(posedge clk) begin
    if (en) begin
      ys[0] <= '0;
      sd[0] <= side_in;
      if (angle > s2c_pkg::ANG_HALF_PI) begin
        zs[0] <= angle - s2c_pkg::ANG_PI;
        xs[0] <= -x0;
      end else if (angle < -s2c_pkg::ANG_HALF_PI) begin
        zs[0] <= angle + s2c_pkg::ANG_PI;
        xs[0] <= -x0;
      end else begin
        zs[0] <= angle;
        xs[0] <= x0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = AW'(s2c_pkg::atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        if (!zs[i][AW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN;
        end
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign cos_out = xs[STAGES];
  assign sin_out = ys[STAGES];
  assign side_out = sd[STAGES];

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (zs[0] <= s2c_pkg::ANG_HALF_PI) && (zs[0] >= -s2c_pkg::ANG_HALF_PI))
    else $error("folded angle outside quarter turn");

  a_start_y: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> ys[0] == '0)
    else $error("rotation start vector not on x axis");

endmodule

@@ rtl/spherical_to_cartesian_pose_top.sv @@
// Spherical to cartesian pose converter. Each item carries a horizontal and a
// vertical angle (Q3.28 rad), a distance (Q16.16 m) and a w,x,y,z quaternion;
// the result is x = -r sin v cos h, y = r sin v sin h, z = r cos v in Q16.16,
// saturated to 33 bits, and the quaternion reordered to x,y,z,w. The datapath
// is a fully pipelined chain of gain multiply, CORDIC rotation by v, gain
// multiply, CORDIC rotation by h and a rounding stage, and one item is
// accepted every cycle while the output is not stalled. A stall on the
// output freezes the whole pipeline; nothing is dropped or repeated.
module spherical_to_cartesian_pose_top #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [s2c_pkg::IN_ANG_W-1:0] angle_horizontal,
  input  logic signed [s2c_pkg::IN_ANG_W-1:0] angle_vertical,
  input  logic [s2c_pkg::DIST_W-1:0]          distance,
  input  logic signed [s2c_pkg::QUAT_W-1:0]   quat_w_in,
  input  logic signed [s2c_pkg::QUAT_W-1:0]   quat_x_in,
  input  logic signed [s2c_pkg::QUAT_W-1:0]   quat_y_in,
  input  logic signed [s2c_pkg::QUAT_W-1:0]   quat_z_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [s2c_pkg::POS_W-1:0]    pos_x,
  output logic signed [s2c_pkg::POS_W-1:0]    pos_y,
  output logic signed [s2c_pkg::POS_W-1:0]    pos_z,
  output logic signed [s2c_pkg::QUAT_W-1:0]   orient_x,
  output logic signed [s2c_pkg::QUAT_W-1:0]   orient_y,
  output logic signed [s2c_pkg::QUAT_W-1:0]   orient_z,
  output logic signed [s2c_pkg::QUAT_W-1:0]   orient_w
);

  localparam int VW = s2c_pkg::VEC_W;
  localparam int AW = s2c_pkg::ANG_W;
  localparam int IAW = s2c_pkg::IN_ANG_W;
  localparam int PW = s2c_pkg::POS_W;
  localparam int QW = $bits(s2c_pkg::quat_t);
  localparam int G1_W = 2 * IAW + QW;
  localparam int C1_W = IAW + QW;
  localparam int G2_W = IAW + VW + QW;
  localparam int C2_W = VW + QW;
  localparam int RW = VW + 2;

  logic en;
  s2c_pkg::quat_t quat_in;
  logic signed [VW-1:0] r_ext;

  logic g1_valid;
  logic signed [VW-1:0] g1_res;
  logic [G1_W-1:0] g1_side;

  logic c1_valid;
  logic signed [VW-1:0] c1_cos;
  logic signed [VW-1:0] c1_sin;
  logic [C1_W-1:0] c1_side;

  logic g2_valid;
  logic signed [VW-1:0] g2_res;
  logic [G2_W-1:0] g2_side;

  logic c2_valid;
  logic signed [VW-1:0] c2_cos;
  logic signed [VW-1:0] c2_sin;
  logic [C2_W-1:0] c2_side;

  logic signed [IAW-1:0] g1_v;
  logic signed [AW-1:0] v_ang;
  logic signed [AW-1:0] h_ang;
  logic signed [VW-1:0] c2_rc;
  s2c_pkg::quat_t c2_quat;

  function automatic logic signed [PW-1:0] round_sat(input logic signed [VW-1:0] v,
                                                      input logic negate);
    logic signed [RW-1:0] t;
    logic signed [RW-1:0] lim_hi;
    logic signed [RW-1:0] lim_lo;
    t = (RW'(v) + RW'(128)) >>> 8;
    lim_hi = RW'({1'b0, {(PW-1){1'b1}}});
    lim_lo = -RW'({1'b1, {(PW-1){1'b0}}});
    if (negate) t = -t;
    if (t > lim_hi) t = lim_hi;
    if (t < lim_lo) t = lim_lo;
    return t[PW-1:0];
  endfunction

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  assign quat_in = '{w: quat_w_in, x: quat_x_in, y: quat_y_in, z: quat_z_in};
  assign r_ext = VW'({distance, 8'd0});

  s2c_gain #(.SIDE_W(G1_W)) u_gain_r (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .a(r_ext), .side_in({angle_vertical, angle_horizontal, quat_in}),
    .out_valid(g1_valid), .result(g1_res), .side_out(g1_side)
  );

  assign g1_v = g1_side[G1_W-1 -: IAW];
  assign v_ang = AW'($signed({g1_v, 2'b00}));

  s2c_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(C1_W)) u_rot_v (
    .clk(clk), .rst(rst), .en(en), .in_valid(g1_valid),
    .x0(g1_res), .angle(v_ang), .side_in(g1_side[C1_W-1:0]),
    .out_valid(c1_valid), .cos_out(c1_cos), .sin_out(c1_sin), .side_out(c1_side)
  );

  s2c_gain #(.SIDE_W(G2_W)) u_gain_s (
    .clk(clk), .rst(rst), .en(en), .in_valid(c1_valid),
    .a(c1_sin), .side_in({c1_side[C1_W-1 -: IAW], c1_cos, c1_side[QW-1:0]}),
    .out_valid(g2_valid), .result(g2_res), .side_out(g2_side)
  );

  assign h_ang = AW'($signed({g2_side[G2_W-1 -: IAW], 2'b00}));

  s2c_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(C2_W)) u_rot_h (
    .clk(clk), .rst(rst), .en(en), .in_valid(g2_valid),
    .x0(g2_res), .angle(h_ang), .side_in(g2_side[C2_W-1:0]),
    .out_valid(c2_valid), .cos_out(c2_cos), .sin_out(c2_sin), .side_out(c2_side)
  );

  assign c2_rc = c2_side[C2_W-1 -: VW];
  assign c2_quat = c2_side[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= round_sat(c2_cos, 1'b1);
      pos_y <= round_sat(c2_sin, 1'b0);
      pos_z <= round_sat(c2_rc, 1'b0);
      orient_x <= c2_quat.x;
      orient_y <= c2_quat.y;
      orient_z <= c2_quat.z;
      orient_w <= c2_quat.w;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(orient_w))
    else $error("stalled result changed");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 24;
  localparam int LATENCY = 2 * STAGES + 7;
  localparam int DRAIN_CYCLES = 2 * LATENCY;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_ITEMS = 880;
  localparam int IAW = s2c_pkg::IN_ANG_W;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint unsigned GAIN_Q30 = 64'd652032874;
  localparam longint POS_HI = 64'sd4294967295;
  localparam longint POS_LO = -64'sd4294967296;

  // input angle codes, Q3.28
  localparam int PI_IN = 843314857;
  localparam int QUARTER_IN = 421657428;  // largest code not folded by pi
  localparam int ANG_MAX = 1073741823;
  localparam int ANG_MIN = -1073741824;

  typedef struct packed {
    logic signed [s2c_pkg::IN_ANG_W-1:0] ang_h;
    logic signed [s2c_pkg::IN_ANG_W-1:0] ang_v;
    logic [s2c_pkg::DIST_W-1:0] radius;
    s2c_pkg::quat_t q;
  } meas_t;

  typedef struct packed {
    logic signed [s2c_pkg::POS_W-1:0] px;
    logic signed [s2c_pkg::POS_W-1:0] py;
    logic signed [s2c_pkg::POS_W-1:0] pz;
    logic signed [s2c_pkg::QUAT_W-1:0] ox;
    logic signed [s2c_pkg::QUAT_W-1:0] oy;
    logic signed [s2c_pkg::QUAT_W-1:0] oz;
    logic signed [s2c_pkg::QUAT_W-1:0] ow;
  } pose_t;

  typedef struct {
    bit fixed;
    logic [s2c_pkg::POS_W-1:0] px;
    logic [s2c_pkg::POS_W-1:0] py;
    logic [s2c_pkg::POS_W-1:0] pz;
  } pin_t;

  typedef struct {
    meas_t m;
    pin_t pin;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [s2c_pkg::IN_ANG_W-1:0] angle_horizontal;
  logic signed [s2c_pkg::IN_ANG_W-1:0] angle_vertical;
  logic [s2c_pkg::DIST_W-1:0] distance;
  logic signed [s2c_pkg::QUAT_W-1:0] quat_w_in;
  logic signed [s2c_pkg::QUAT_W-1:0] quat_x_in;
  logic signed [s2c_pkg::QUAT_W-1:0] quat_y_in;
  logic signed [s2c_pkg::QUAT_W-1:0] quat_z_in;
  logic out_valid;
  logic out_stall;
  logic signed [s2c_pkg::POS_W-1:0] pos_x;
  logic signed [s2c_pkg::POS_W-1:0] pos_y;
  logic signed [s2c_pkg::POS_W-1:0] pos_z;
  logic signed [s2c_pkg::QUAT_W-1:0] orient_x;
  logic signed [s2c_pkg::QUAT_W-1:0] orient_y;
  logic signed [s2c_pkg::QUAT_W-1:0] orient_z;
  logic signed [s2c_pkg::QUAT_W-1:0] orient_w;

  pose_t pending_poses[$];
  pin_t pinned_q[$];
  row_t plan[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  longint arctan_step [0:31] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  spherical_to_cartesian_pose_top #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .angle_horizontal(angle_horizontal),
    .angle_vertical(angle_vertical),
    .distance(distance),
    .quat_w_in(quat_w_in),
    .quat_x_in(quat_x_in),
    .quat_y_in(quat_y_in),
    .quat_z_in(quat_z_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .orient_x(orient_x),
    .orient_y(orient_y),
    .orient_z(orient_z),
    .orient_w(orient_w)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // magnitude times the cordic gain, truncated toward zero
  function automatic longint gain_comp(input longint a);
    longint unsigned mag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned prod;
    mag = (a < 0) ? -a : a;
    hi = (mag >> 16) * GAIN_Q30;
    lo = (mag & 64'hFFFF) * GAIN_Q30;
    prod = (hi + (lo >> 16)) >> 14;
    return (a < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic void rotate_vec(input longint x0, input longint ang,
                                     output longint cx, output longint sy);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = x0;
    y = 0;
    z = ang;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      x = -x;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      x = -x;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_step[i];
      end
    end
    cx = x;
    sy = y;
  endfunction

  function automatic longint round_q16(input longint v);
    return (v + 128) >>> 8;
  endfunction

  function automatic logic [s2c_pkg::POS_W-1:0] clamp_pos(input longint v);
    if (v > POS_HI) v = POS_HI;
    if (v < POS_LO) v = POS_LO;
    return v[s2c_pkg::POS_W-1:0];
  endfunction

  function automatic pose_t pose_from_meas(input meas_t m);
    longint h;
    longint v;
    longint r;
    longint rc;
    longint rs;
    longint hc;
    longint hs;
    pose_t p;
    h = longint'($signed(m.ang_h)) * 4;
    v = longint'($signed(m.ang_v)) * 4;
    r = longint'(m.radius) << 8;
    rotate_vec(gain_comp(r), v, rc, rs);
    rotate_vec(gain_comp(rs), h, hc, hs);
    p.px = clamp_pos(-round_q16(hc));
    p.py = clamp_pos(round_q16(hs));
    p.pz = clamp_pos(round_q16(rc));
    p.ox = m.q.x;
    p.oy = m.q.y;
    p.oz = m.q.z;
    p.ow = m.q.w;
    return p;
  endfunction

  function automatic logic [s2c_pkg::IN_ANG_W-1:0] rand_angle();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return IAW'($urandom());  // full code range, up to 4 rad
    if (sel == 1) begin
      // around the quarter turn fold
      if ($urandom_range(0, 1)) return IAW'(QUARTER_IN + $urandom_range(0, 4) - 2);
      return IAW'(-QUARTER_IN + $urandom_range(0, 4) - 2);
    end
    return IAW'($urandom_range(0, 1686629714) - PI_IN);
  endfunction

  function automatic logic [s2c_pkg::QUAT_W-1:0] rand_quat();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $urandom_range(0, 32'h80000000) - 32'h40000000;
  endfunction

  function automatic meas_t rand_meas();
    meas_t m;
    m.ang_h = rand_angle();
    m.ang_v = rand_angle();
    case ($urandom_range(0, 3))
      0: m.radius = $urandom_range(0, 32'h000FFFFF);
      1: m.radius = 32'hFFFFFFFF - $urandom_range(0, 255);
      default: m.radius = $urandom();
    endcase
    m.q.w = rand_quat();
    m.q.x = rand_quat();
    m.q.y = rand_quat();
    m.q.z = rand_quat();
    return m;
  endfunction

  task automatic add_row(input int h, input int v, input logic [31:0] d,
                         input logic [31:0] qw, input logic [31:0] qx,
                         input logic [31:0] qy, input logic [31:0] qz,
                         input bit fixed, input logic [s2c_pkg::POS_W-1:0] ex,
                         input logic [s2c_pkg::POS_W-1:0] ey,
                         input logic [s2c_pkg::POS_W-1:0] ez);
    row_t row;
    row.m.ang_h = IAW'(h);
    row.m.ang_v = IAW'(v);
    row.m.radius = d;
    row.m.q.w = qw;
    row.m.q.x = qx;
    row.m.q.y = qy;
    row.m.q.z = qz;
    row.pin.fixed = fixed;
    row.pin.px = ex;
    row.pin.py = ey;
    row.pin.pz = ez;
    plan.push_back(row);
  endtask

  task automatic send_item(input meas_t m, input pin_t pin);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pinned_q.push_back(pin);
    angle_horizontal <= m.ang_h;
    angle_vertical <= m.ang_v;
    distance <= m.radius;
    quat_w_in <= m.q.w;
    quat_x_in <= m.q.x;
    quat_y_in <= m.q.y;
    quat_z_in <= m.q.z;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [s2c_pkg::POS_W-1:0] want,
                             input logic [s2c_pkg::POS_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb_top: %s mismatch, expected %h, got %h", name, want, got);
    end
  endtask

  // result checking
  always @(posedge clk) begin : scoreboard
    meas_t cur;
    pose_t want;
    pose_t got;
    pin_t pin;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        cur.ang_h = angle_horizontal;
        cur.ang_v = angle_vertical;
        cur.radius = distance;
        cur.q.w = quat_w_in;
        cur.q.x = quat_x_in;
        cur.q.y = quat_y_in;
        cur.q.z = quat_z_in;
        want = pose_from_meas(cur);
        pin = pinned_q.pop_front();
        if (pin.fixed) begin
          want.px = pin.px;
          want.py = pin.py;
          want.pz = pin.pz;
        end
        pending_poses.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {pos_x, pos_y, pos_z, orient_x, orient_y, orient_z, orient_w};
        if (pending_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("tb_top: result with no item pending: %h", got);
        end else begin
          want = pending_poses.pop_front();
          check_field("pos_x", want.px, got.px);
          check_field("pos_y", want.py, got.py);
          check_field("pos_z", want.pz, got.pz);
          check_field("orient_x", {1'b0, want.ox}, {1'b0, got.ox});
          check_field("orient_y", {1'b0, want.oy}, {1'b0, got.oy});
          check_field("orient_z", {1'b0, want.oz}, {1'b0, got.oz});
          check_field("orient_w", {1'b0, want.ow}, {1'b0, got.ow});
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  // sender side
  initial begin
    pin_t no_pin;
    rst = 1'b1;
    in_valid = 1'b0;
    angle_horizontal = '0;
    angle_vertical = '0;
    distance = '0;
    quat_w_in = '0;
    quat_x_in = '0;
    quat_y_in = '0;
    quat_z_in = '0;
    no_pin.fixed = 1'b0;
    no_pin.px = '0;
    no_pin.py = '0;
    no_pin.pz = '0;

    // zero distance gives a zero position whatever the angles
    add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(ANG_MAX, ANG_MIN, 0, 32'h7FFFFFFF, 32'h80000000, 32'h40000000, 32'hC0000000,
            1, 0, 0, 0);
    add_row(PI_IN, -PI_IN, 0, 32'hFFFFFFFF, 32'h00000001, 32'hBFFFFFFF, 32'h40000001,
            1, 0, 0, 0);
    add_row(0, 0, 32'hFFFFFFFF, 32'h40000000, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, PI_IN, 32'hFFFFFFFF, 0, 32'h40000000, 0, 0, 0, 0, 0, 0);
    add_row(0, -PI_IN, 32'hFFFFFFFF, 0, 0, 32'h40000000, 0, 0, 0, 0, 0);
    add_row(0, QUARTER_IN, 32'hFFFFFFFF, 0, 0, 0, 32'h40000000, 0, 0, 0, 0);
    add_row(0, QUARTER_IN + 1, 32'hFFFFFFFF, 32'hC0000000, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, -QUARTER_IN, 32'hFFFFFFFF, 0, 32'hC0000000, 0, 0, 0, 0, 0, 0);
    add_row(0, -QUARTER_IN - 1, 32'hFFFFFFFF, 0, 0, 32'hC0000000, 0, 0, 0, 0, 0);
    add_row(QUARTER_IN, QUARTER_IN, 32'hFFFFFFFF, 0, 0, 0, 32'hC0000000, 0, 0, 0, 0);
    add_row(QUARTER_IN + 1, QUARTER_IN, 32'hFFFFFFFF, 1, 2, 3, 4, 0, 0, 0, 0);
    add_row(-QUARTER_IN - 1, -QUARTER_IN, 32'hFFFFFFFF, -1, -2, -3, -4, 0, 0, 0, 0);
    add_row(PI_IN, QUARTER_IN, 32'hFFFFFFFF, 32'h2D413CCD, 0, 0, 32'h2D413CCD, 0, 0, 0, 0);
    add_row(-PI_IN, QUARTER_IN, 32'hFFFFFFFF, 32'h2D413CCD, 32'hD2BEC333, 0, 0, 0, 0, 0, 0);
    add_row(ANG_MAX, ANG_MAX, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 0, 0, 0, 0);
    add_row(ANG_MIN, ANG_MIN, 32'hFFFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 0, 0, 0, 0);
    add_row(ANG_MIN, ANG_MAX, 32'h80000000, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
            32'hAAAAAAAA, 0, 0, 0, 0);
    add_row(0, 0, 1, 32'h40000000, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h00010000, 32'h40000000, 0, 0, 0, 0, 0, 0, 0);
    add_row(-1, 1, 32'h0000FFFF, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
            0, 0, 0, 0);
    add_row(12345678, -98765432, 32'h12345678, 32'hC0000000, 32'h1E2D3C4B, 32'hF0E1D2C3,
            32'h0F1E2D3C, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) send_item(plan[i].m, plan[i].pin);

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == 250) calm = 1'b1;
      if (k == 450) begin
        // receiver holds off while items keep coming
        calm = 1'b0;
        hold_req = 1'b1;
      end
      if (k == 650) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_poses.size() != 0) @(negedge clk);
      end
      send_item(rand_meas(), no_pin);
    end

    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
